@@ rtl/core/gyro_bias_calibrate_correct_defines.svh @@
// Assertion macros for the gyro bias calibration RTL
`ifndef GYRO_BIAS_CALIBRATE_CORRECT_DEFINES_SVH
`define GYRO_BIAS_CALIBRATE_CORRECT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising aclk edge outside reset
`define GBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Condition that must never be seen outside reset
`define GBC_ASSERT_NEVER(lbl, cond, msg) \
    `GBC_ASSERT(lbl, !(cond), msg)
`else
`define GBC_ASSERT(lbl, prop, msg)
`define GBC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/gbc_pkg.sv @@
// Constants, codes and reciprocal for the gyro bias calibration block
package gbc_pkg;

    // Samples summed per calibration run
    localparam int NUM_SAMPLES = 100;
    localparam int NUM_AXES    = 3;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int RATE_W  = 21;
    localparam int SUM_W   = 24;
    localparam int COUNT_W = 10;
    localparam int LIMIT_W = 16;
    localparam int DIFF_W  = RATE_W + 1;
    localparam int MAG_W   = SUM_W + 4;   // |sum * 16|

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = ((NUM_AXES * RAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUM_AXES * RATE_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 8;

    // Division by NUM_SAMPLES as multiply by a rounded-up reciprocal.
    // With SHIFT this large the floor of the product is exact for |n| < 2^(MAG_W-1)+1.
    localparam int          SHIFT     = MAG_W + $clog2(NUM_SAMPLES);
    localparam logic [63:0] RECIP_64  = ((64'd1 << SHIFT) + NUM_SAMPLES - 1) / NUM_SAMPLES;
    localparam int          RECIP_W   = SHIFT - $clog2(NUM_SAMPLES) + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);
    localparam int          PROD_W    = MAG_W + RECIP_W;
    localparam int          QUOT_W    = PROD_W - SHIFT;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_CALIB   = 2'd0,
        STATUS_REJECT  = 2'd1,
        STATUS_ACCEPT  = 2'd2,
        STATUS_MEASURE = 2'd3
    } status_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LIMIT_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LIMIT_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LIMIT_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_Z_DEADBAND   = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [LIMIT_W-1:0] BIAS_LIMIT_X_RST = LIMIT_W'(3936);
    localparam logic [LIMIT_W-1:0] BIAS_LIMIT_Y_RST = LIMIT_W'(1312);
    localparam logic [LIMIT_W-1:0] BIAS_LIMIT_Z_RST = LIMIT_W'(472);
    localparam logic [LIMIT_W-1:0] Z_DEADBAND_RST   = LIMIT_W'(79);

endpackage

@@ rtl/core/gyro_bias_calibrate_correct.sv @@
// Gyro zero-rate bias calibration and bias correction, top level
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: raw_x, raw_y, raw_z
//  m_      | out | m_tvalid/m_tready  | tdata: rate_x, rate_y, rate_z; tuser: status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (bias limits, deadband)
//
// One sample per cycle while s_tready is high; its result is registered and appears
// the next cycle. The sample that completes a calibration run passes through S_MUL,
// which registers the divide-by-NUM_SAMPLES multiply, and S_DEC, which makes the limit
// check once m_ is free; no sample is taken meanwhile (once every NUM_SAMPLES samples).
// aresetn is synchronous, active low; it restarts calibration.
// A stalled m_ side holds its result and drops s_tready until taken.
`include "gyro_bias_calibrate_correct_defines.svh"

module gyro_bias_calibrate_correct (
    input  logic                              aclk,
    input  logic                              aresetn,
    // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  logic [gbc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rate_x [20:0], rate_y [41:21], rate_z [62:42], zero pad [63]
    output logic [gbc_pkg::M_TDATA_W-1:0]     m_tdata,
    // status [1:0], zero pad [7:2]
    output logic [gbc_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gbc_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_MUL,
        S_DEC
    } state_t;

    state_t               state_reg;
    logic [LIMIT_W-1:0]   limit_reg [NUM_AXES];
    logic [LIMIT_W-1:0]   z_deadband_reg;
    logic [SUM_W-1:0]     sum_reg   [NUM_AXES];
    logic [COUNT_W-1:0]   sample_count_reg;
    logic [RATE_W-1:0]    bias_reg  [NUM_AXES];
    logic                 calibrated_reg;
    logic [PROD_W-1:0]    prod_reg  [NUM_AXES];
    logic                 neg_reg   [NUM_AXES];
    logic [RATE_W-1:0]    rate_reg  [NUM_AXES];
    status_t              status_reg;
    logic                 m_tvalid_reg;

    logic [RAW_W-1:0]     raw       [NUM_AXES];
    logic [SUM_W-1:0]     sum_next  [NUM_AXES];
    logic [PROD_W-1:0]    prod_next [NUM_AXES];
    logic                 neg_next  [NUM_AXES];
    logic [RATE_W-1:0]    rate_next [NUM_AXES];
    logic [RATE_W-1:0]    bias_next [NUM_AXES];
    logic [NUM_AXES-1:0]  within_limit;
    logic [COUNT_W-1:0]   sample_count_next;
    logic                 out_free;
    logic                 in_fire;
    logic                 result_load;

    // Handshake
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_RUN) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign sample_count_next = sample_count_reg + COUNT_W'(1);

    // New result: every sample transfer but the one ending a run, and each decision
    assign result_load = (in_fire && (calibrated_reg ||
                                      sample_count_next != COUNT_W'(NUM_SAMPLES)))
                       || (state_reg == S_DEC && out_free);

    // Per-axis datapath: accumulate, divide stage, limit check, correction
    always_comb begin
        logic [MAG_W-1:0]  scaled;
        logic [MAG_W-1:0]  mag;
        logic [QUOT_W-1:0] quot;
        logic [MAG_W-1:0]  quot_ext;
        logic [MAG_W-1:0]  bias_wide;
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] diff_mag;
        for (int i = 0; i < NUM_AXES; i++) begin
            raw[i]      = s_tdata[i*RAW_W +: RAW_W];
            sum_next[i] = sum_reg[i] + {{(SUM_W-RAW_W){raw[i][RAW_W-1]}}, raw[i]};

            // |sum * 16| times the reciprocal
            scaled       = {sum_reg[i], 4'b0000};
            neg_next[i]  = scaled[MAG_W-1];
            mag          = neg_next[i] ? (~scaled + MAG_W'(1)) : scaled;
            prod_next[i] = PROD_W'(mag) * PROD_W'(RECIP);

            // Quotient is the bias magnitude; restore the sign
            quot            = prod_reg[i][SHIFT +: QUOT_W];
            within_limit[i] = quot < QUOT_W'(limit_reg[i]);
            quot_ext        = MAG_W'(quot);
            bias_wide       = neg_reg[i] ? (~quot_ext + MAG_W'(1)) : quot_ext;
            bias_next[i]    = bias_wide[RATE_W-1:0];

            // raw * 16 - bias
            diff = {{(DIFF_W-RAW_W-4){raw[i][RAW_W-1]}}, raw[i], 4'b0000}
                 - {bias_reg[i][RATE_W-1], bias_reg[i]};
            diff_mag     = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
            rate_next[i] = diff[RATE_W-1:0];
            // Deadband on z only
            if (i == NUM_AXES - 1 && diff_mag < DIFF_W'(z_deadband_reg)) begin
                rate_next[i] = '0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg[0]   <= BIAS_LIMIT_X_RST;
            limit_reg[1]   <= BIAS_LIMIT_Y_RST;
            limit_reg[2]   <= BIAS_LIMIT_Z_RST;
            z_deadband_reg <= Z_DEADBAND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BIAS_LIMIT_X: limit_reg[0]   <= cfg_data;
                CFG_BIAS_LIMIT_Y: limit_reg[1]   <= cfg_data;
                CFG_BIAS_LIMIT_Z: limit_reg[2]   <= cfg_data;
                CFG_Z_DEADBAND:   z_deadband_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control, calibration state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_RUN;
            m_tvalid_reg     <= 1'b0;
            calibrated_reg   <= 1'b0;
            sample_count_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end else begin
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_RUN: begin
                    if (in_fire) begin
                        if (calibrated_reg) begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                rate_reg[i] <= rate_next[i];
                            end
                            status_reg   <= STATUS_MEASURE;
                        end else begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                sum_reg[i] <= sum_next[i];
                            end
                            if (sample_count_next == COUNT_W'(NUM_SAMPLES)) begin
                                // run complete: result follows from the divide
                                sample_count_reg <= '0;
                                state_reg        <= S_MUL;
                            end else begin
                                sample_count_reg <= sample_count_next;
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    rate_reg[i] <= '0;
                                end
                                status_reg   <= STATUS_CALIB;
                            end
                        end
                    end
                end
                S_MUL: begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        prod_reg[i] <= prod_next[i];
                        neg_reg[i]  <= neg_next[i];
                    end
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (out_free) begin
                        if (&within_limit) begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                bias_reg[i] <= bias_next[i];
                            end
                            calibrated_reg <= 1'b1;
                            status_reg     <= STATUS_ACCEPT;
                        end else begin
                            for (int i = 0; i < NUM_AXES; i++) begin
                                sum_reg[i] <= '0;
                            end
                            status_reg <= STATUS_REJECT;
                        end
                        for (int i = 0; i < NUM_AXES; i++) begin
                            rate_reg[i] <= '0;
                        end
                        state_reg    <= S_RUN;
                    end
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end

    // Output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({rate_reg[2], rate_reg[1], rate_reg[0]});
    assign m_tuser  = M_TUSER_W'(status_reg);

    // Checks
    `GBC_ASSERT(a_calib_holds, $past(aresetn) && $past(calibrated_reg) |-> calibrated_reg, "calibration lost without reset")
    `GBC_ASSERT(a_measure_only_calib, m_tvalid_reg && status_reg == STATUS_MEASURE |-> calibrated_reg, "measurement result before calibration")
    `GBC_ASSERT(a_accept_result, $rose(calibrated_reg) |-> m_tvalid_reg && status_reg == STATUS_ACCEPT, "accepted calibration without result")
    `GBC_ASSERT(a_dec_result, state_reg == S_DEC && out_free |=> m_tvalid_reg && (status_reg == STATUS_ACCEPT || status_reg == STATUS_REJECT), "decision result missing")
    `GBC_ASSERT_NEVER(a_count_range, sample_count_reg >= COUNT_W'(NUM_SAMPLES), "sample count past run length")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the gyro bias calibration and rate correction block
module tb_top;
    import gbc_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES    = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DIR_ROWS       = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    // x in the lowest bits, as on the tdata buses
    typedef logic [NUM_AXES-1:0][RAW_W-1:0] raw_smp_t;

    typedef struct packed {
        status_t                         status;
        logic [NUM_AXES-1:0][RATE_W-1:0] rate;
    } rate_res_t;

    // typed = 1: expected result written in the stimulus, not predicted
    typedef struct packed {
        logic      typed;
        rate_res_t res;
    } pinned_t;

    typedef struct packed {
        logic signed [RAW_W-1:0]  x, y, z;
        status_t                  status;
        logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
    } dir_row_t;

    typedef enum {SMP_FULL, SMP_CLUSTER, SMP_CONST, SMP_MEAS} smp_kind_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic [S_TDATA_W-1:0]     s_tdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic [M_TUSER_W-1:0]     m_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // Predictor state
    logic signed [SUM_W-1:0]  cal_sum  [NUM_AXES];
    logic [COUNT_W-1:0]       cal_count;
    logic signed [RATE_W-1:0] cal_bias [NUM_AXES];
    logic                     cal_done;
    logic [LIMIT_W-1:0]       bias_limit [NUM_AXES];
    logic [LIMIT_W-1:0]       z_deadband;

    rate_res_t   rate_expect_q [$];
    pinned_t     pinned_q [$];
    int unsigned mismatch_count = 0;

    // Stimulus shaping
    bit idle_on     = 1'b1;
    bit rx_hold_req = 1'b0;
    bit z_edge_on   = 1'b0;
    int cluster_centre [NUM_AXES];
    int z_edge_raw;

    // Field extremes and bit patterns while calibrating: rates read as zero
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{16'sd0,      16'sd0,      16'sd0,      STATUS_CALIB, '0, '0, '0},
        '{16'sh7FFF,   16'sh7FFF,   16'sh7FFF,   STATUS_CALIB, '0, '0, '0},
        '{16'sh8000,   16'sh8000,   16'sh8000,   STATUS_CALIB, '0, '0, '0},
        '{16'shFFFF,   16'shFFFF,   16'shFFFF,   STATUS_CALIB, '0, '0, '0},
        '{16'sd1,      16'sd1,      16'sd1,      STATUS_CALIB, '0, '0, '0},
        '{16'sh7FFF,   16'sh8000,   16'sd0,      STATUS_CALIB, '0, '0, '0},
        '{16'sh8000,   16'sd0,      16'sh7FFF,   STATUS_CALIB, '0, '0, '0},
        '{16'sd0,      16'sh7FFF,   16'sh8000,   STATUS_CALIB, '0, '0, '0},
        '{16'sh5555,   16'shAAAA,   16'sh00FF,   STATUS_CALIB, '0, '0, '0},
        '{16'shAAAA,   16'sh5555,   16'shFF00,   STATUS_CALIB, '0, '0, '0},
        '{16'sh0F0F,   16'shF0F0,   16'sh7FFE,   STATUS_CALIB, '0, '0, '0},
        '{16'sh8001,   16'sd1,      -16'sd2,     STATUS_CALIB, '0, '0, '0},
        '{16'sd16384,  -16'sd16384, 16'sd8192,   STATUS_CALIB, '0, '0, '0},
        '{16'shFFFF,   16'sh7FFF,   16'sd1,      STATUS_CALIB, '0, '0, '0},
        '{16'sd4096,   -16'sd4097,  16'sh8000,   STATUS_CALIB, '0, '0, '0},
        '{16'sd2,      -16'sd2,     16'sh7FFF,   STATUS_CALIB, '0, '0, '0}
    };

    gyro_bias_calibrate_correct dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),     // raw_x, raw_y, raw_z
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),     // rate_x, rate_y, rate_z, pad
        .m_tuser   (m_tuser),     // status, pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Expected result of one sample; advances the calibration state
    task automatic predict_rate(input raw_smp_t smp, output rate_res_t res);
        longint scaled [NUM_AXES];
        longint zmag;
        logic   in_limits;
        res.status = STATUS_CALIB;
        res.rate   = '0;
        if (cal_done) begin
            for (int a = 0; a < NUM_AXES; a++)
                res.rate[a] = RATE_W'(longint'($signed(smp[a])) * 16 - longint'(cal_bias[a]));
            zmag = longint'($signed(res.rate[2]));
            if (zmag < 0) zmag = -zmag;
            if (zmag < longint'(z_deadband)) res.rate[2] = '0;
            res.status = STATUS_MEASURE;
        end else begin
            // the completing sample is part of the sum
            for (int a = 0; a < NUM_AXES; a++)
                cal_sum[a] = cal_sum[a] + $signed(smp[a]);
            cal_count = cal_count + 1'b1;
            if (cal_count >= NUM_SAMPLES) begin
                in_limits = 1'b1;
                for (int a = 0; a < NUM_AXES; a++) begin
                    // truncates toward zero
                    scaled[a] = longint'(cal_sum[a]) * 16 / NUM_SAMPLES;
                    if ((scaled[a] < 0 ? -scaled[a] : scaled[a]) >= longint'(bias_limit[a]))
                        in_limits = 1'b0;
                end
                cal_count = '0;
                if (in_limits) begin
                    for (int a = 0; a < NUM_AXES; a++) cal_bias[a] = RATE_W'(scaled[a]);
                    cal_done   = 1'b1;
                    res.status = STATUS_ACCEPT;
                end else begin
                    for (int a = 0; a < NUM_AXES; a++) cal_sum[a] = '0;
                    res.status = STATUS_REJECT;
                end
            end
        end
    endtask

    // Register writes, sample transfers in and result transfers out
    always @(posedge aclk) begin : scoreboard
        rate_res_t predicted;
        rate_res_t want;
        rate_res_t got;
        pinned_t   pin;
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                cal_sum[a]  = '0;
                cal_bias[a] = '0;
            end
            cal_count     = '0;
            cal_done      = 1'b0;
            bias_limit[0] = BIAS_LIMIT_X_RST;
            bias_limit[1] = BIAS_LIMIT_Y_RST;
            bias_limit[2] = BIAS_LIMIT_Z_RST;
            z_deadband    = Z_DEADBAND_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BIAS_LIMIT_X: bias_limit[0] = cfg_data;
                    CFG_BIAS_LIMIT_Y: bias_limit[1] = cfg_data;
                    CFG_BIAS_LIMIT_Z: bias_limit[2] = cfg_data;
                    CFG_Z_DEADBAND:   z_deadband    = cfg_data;
                    default: ;  // unused index, ignored
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_rate(s_tdata, predicted);
                pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
                rate_expect_q.push_back(pin.typed ? pin.res : predicted);
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser[1:0]);
                got.rate   = m_tdata[NUM_AXES*RATE_W-1:0];
                if (rate_expect_q.size() == 0) begin
                    $display("%0t: result transfer with none expected, tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    mismatch_count++;
                end else begin
                    want = rate_expect_q.pop_front();
                    for (int a = 0; a < NUM_AXES; a++) begin
                        if (got.rate[a] !== want.rate[a]) begin
                            $display("%0t: rate axis %0d expected %0d, got %0d", $time, a,
                                     $signed(want.rate[a]), $signed(got.rate[a]));
                            mismatch_count++;
                        end
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, got.status);
                        mismatch_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:NUM_AXES*RATE_W] !== '0 ||
                        m_tuser[M_TUSER_W-1:2] !== '0) begin
                        $display("%0t: padding expected 0, got tdata %h tuser %h", $time,
                                 m_tdata[M_TDATA_W-1:NUM_AXES*RATE_W], m_tuser[M_TUSER_W-1:2]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Receiver pacing: ready bursts, random stalls, one long hold on request
    initial begin : rx_pacing
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic raw_smp_t make_sample(input smp_kind_t kind);
        raw_smp_t    smp;
        int          v;
        int unsigned pick;
        for (int a = 0; a < NUM_AXES; a++) begin
            case (kind)
                SMP_CLUSTER: v = cluster_centre[a] + int'($urandom_range(0, 128)) - 64;
                SMP_CONST:   v = cluster_centre[a];
                default:     v = int'($urandom_range(0, 65535));
            endcase
            smp[a] = RAW_W'(v);
        end
        // steer z around the bias so the deadband is hit from both sides
        if (kind == SMP_MEAS) begin
            pick = $urandom_range(0, 3);
            if (pick == 0 && z_edge_on)
                smp[2] = RAW_W'(z_edge_raw);
            else if (pick <= 1)
                smp[2] = RAW_W'((int'(cal_bias[2]) >>> 4) + int'($urandom_range(0, 16)) - 8);
        end
        return smp;
    endfunction

    task automatic pick_centres(input int spread);
        for (int a = 0; a < NUM_AXES; a++)
            cluster_centre[a] = int'($urandom_range(0, 2 * spread)) - spread;
    endtask

    task automatic send_sample(input raw_smp_t smp, input pinned_t pin);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        pinned_q.push_back(pin);
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic feed(input int count, input smp_kind_t kind);
        repeat (count) send_sample(make_sample(kind), '0);
    endtask

    // Sender stops until every expected result has been taken
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (rate_expect_q.size() != 0 || pinned_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    initial begin : stimulus
        dir_row_t    row;
        rate_res_t   want;
        int unsigned attempt;
        int          z_edge_mag;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, all inside the first calibration run
        for (int r = 0; r < DIR_ROWS; r++) begin
            row         = directed_rows[r];
            want.status = row.status;
            want.rate   = {row.rate_z, row.rate_y, row.rate_x};
            send_sample({row.z, row.y, row.x}, '{typed: 1'b1, res: want});
        end
        await_results();

        // Unused index is ignored; x limit of zero rejects the first run
        write_reg(CFG_IDX_W'(int'(CFG_Z_DEADBAND) + 1 + $urandom_range(0, 251)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_BIAS_LIMIT_X, '0);
        cfg_valid <= 1'b0;
        feed(NUM_SAMPLES - DIR_ROWS, SMP_FULL);
        await_results();

        // y limit of zero rejects
        write_reg(CFG_BIAS_LIMIT_X, LIMIT_MAX);
        write_reg(CFG_BIAS_LIMIT_Y, '0);
        cfg_valid <= 1'b0;
        pick_centres(2000);
        feed(NUM_SAMPLES, SMP_CLUSTER);
        await_results();

        // z limit of zero rejects
        write_reg(CFG_BIAS_LIMIT_Y, LIMIT_MAX);
        write_reg(CFG_BIAS_LIMIT_Z, '0);
        cfg_valid <= 1'b0;
        pick_centres(2000);
        feed(NUM_SAMPLES, SMP_CLUSTER);
        await_results();

        // constant samples: x bias equals its limit exactly, so still rejected
        pick_centres(4095);
        write_reg(CFG_BIAS_LIMIT_Z, LIMIT_MAX);
        write_reg(CFG_BIAS_LIMIT_X, CFG_DATA_W'(16 * (cluster_centre[0] < 0 ?
                                     -cluster_centre[0] : cluster_centre[0])));
        cfg_valid <= 1'b0;
        feed(NUM_SAMPLES, SMP_CONST);
        await_results();

        // random limits first, then wide open until a run is accepted
        attempt = 0;
        while (!cal_done) begin
            write_reg(CFG_BIAS_LIMIT_X, attempt == 0 ? LIMIT_W'($urandom_range(0, 65535)) : LIMIT_MAX);
            write_reg(CFG_BIAS_LIMIT_Y, attempt == 0 ? LIMIT_W'($urandom_range(0, 65535)) : LIMIT_MAX);
            write_reg(CFG_BIAS_LIMIT_Z, attempt == 0 ? LIMIT_W'($urandom_range(0, 65535)) : LIMIT_MAX);
            cfg_valid <= 1'b0;
            pick_centres(2000);
            feed(NUM_SAMPLES, SMP_CLUSTER);
            await_results();
            attempt++;
        end

        // Measuring; limits changed now must not matter. Receiver holds off
        // long enough for the input side to back up.
        write_reg(CFG_BIAS_LIMIT_X, '0);
        write_reg(CFG_BIAS_LIMIT_Y, '0);
        write_reg(CFG_BIAS_LIMIT_Z, '0);
        cfg_valid <= 1'b0;
        rx_hold_req = 1'b1;
        feed(80, SMP_MEAS);
        await_results();

        write_reg(CFG_Z_DEADBAND, '0);
        cfg_valid <= 1'b0;
        feed(50, SMP_MEAS);
        await_results();

        write_reg(CFG_Z_DEADBAND, LIMIT_MAX);
        cfg_valid <= 1'b0;
        feed(50, SMP_MEAS);
        await_results();

        // z result magnitude exactly at the deadband passes, one below is zeroed
        z_edge_raw = (int'(cal_bias[2]) >>> 4) + int'($urandom_range(0, 4000)) - 2000;
        z_edge_mag = z_edge_raw * 16 - int'(cal_bias[2]);
        if (z_edge_mag < 0) z_edge_mag = -z_edge_mag;
        z_edge_on = 1'b1;
        write_reg(CFG_Z_DEADBAND, CFG_DATA_W'(z_edge_mag));
        cfg_valid <= 1'b0;
        feed(50, SMP_MEAS);
        await_results();

        write_reg(CFG_Z_DEADBAND, CFG_DATA_W'(z_edge_mag + 1));
        cfg_valid <= 1'b0;
        feed(50, SMP_MEAS);
        await_results();

        // last stretch at full rate, no idling on either side
        z_edge_on = 1'b0;
        idle_on   = 1'b0;
        write_reg(CFG_BIAS_LIMIT_X, LIMIT_W'($urandom_range(0, 65535)));
        write_reg(CFG_Z_DEADBAND, CFG_DATA_W'($urandom_range(0, 1023)));
        cfg_valid <= 1'b0;
        feed(100, SMP_MEAS);
        await_results();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && rate_expect_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/gbc_pkg.sv
rtl/core/gyro_bias_calibrate_correct.sv
bench/tb_top.sv
